[rtl/cst_pkg.sv]
// Shared constants, types and register codes for the clip-space triangle cull core.
`default_nettype none
package cst_pkg;

  // Fixed point and arithmetic widths
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int COF_SHIFT = 2 * FRAC_BITS - 12;
  localparam int PROD_W    = 2 * COORD_W;
  localparam int COF_W     = PROD_W + 1;
  localparam int CS_W      = COF_W - COF_SHIFT;
  // cofactor width as carried downstream: at least one bit above the low word
  localparam int CE_W      = (CS_W > COORD_W + 1) ? CS_W : COORD_W + 1;
  localparam int CH_W      = CE_W - COORD_W;
  localparam int PL_W      = 2 * COORD_W + 1;
  localparam int PH_W      = CH_W + COORD_W;
  localparam int TERM_W    = CE_W + COORD_W;
  localparam int SUM_W     = TERM_W + 2;

  // Configuration port
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  localparam logic [1:0] REG_CULL_ENABLE     = 2'd0;
  localparam logic [1:0] REG_CULL_FACE_MODE  = 2'd1;
  localparam logic [1:0] REG_WINDING_INVERT  = 2'd2;
  localparam logic [1:0] REG_TWO_SIDED_LIGHT = 2'd3;

  // Cull face modes; the unused code behaves as front
  localparam logic [1:0] CULL_FRONT = 2'd0;
  localparam logic [1:0] CULL_REAR  = 2'd1;
  localparam logic [1:0] CULL_BOTH  = 2'd2;

  // Face sign codes
  localparam logic [1:0] FACE_ZERO = 2'b00;
  localparam logic [1:0] FACE_POS  = 2'b01;
  localparam logic [1:0] FACE_NEG  = 2'b11;

  typedef struct packed {
    logic       cull_enable;
    logic [1:0] cull_face_mode;
    logic       winding_invert;
    logic       two_sided_light;
  } cst_cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] v0_x;
    logic signed [COORD_W-1:0] v0_y;
    logic signed [COORD_W-1:0] v0_w;
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [COORD_W-1:0] v1_w;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [COORD_W-1:0] v2_w;
  } cst_tri_t;

endpackage
`default_nettype wire

[rtl/cst_if.sv]
// Handshake channel interfaces: triangle input and cull result.
`default_nettype none
interface cst_tri_if import cst_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] v0_x;
  logic signed [COORD_W-1:0] v0_y;
  logic signed [COORD_W-1:0] v0_w;
  logic signed [COORD_W-1:0] v1_x;
  logic signed [COORD_W-1:0] v1_y;
  logic signed [COORD_W-1:0] v1_w;
  logic signed [COORD_W-1:0] v2_x;
  logic signed [COORD_W-1:0] v2_y;
  logic signed [COORD_W-1:0] v2_w;

  modport source (output valid, v0_x, v0_y, v0_w, v1_x, v1_y, v1_w, v2_x, v2_y, v2_w,
                  input ready);
  modport sink   (input valid, v0_x, v0_y, v0_w, v1_x, v1_y, v1_w, v2_x, v2_y, v2_w,
                  output ready);
endinterface

interface cst_res_if;
  logic              valid;
  logic              ready;
  logic              accept;
  logic              back_colors;
  logic signed [1:0] face_sign;

  modport source (output valid, accept, back_colors, face_sign, input ready);
  modport sink   (input valid, accept, back_colors, face_sign, output ready);
endinterface
`default_nettype wire

[rtl/cst_regs.sv]
// APB configuration registers for the cull decision.
`default_nettype none
module cst_regs import cst_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cst_cfg_t               cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cull_enable     <= 1'b0;
      cfg.cull_face_mode  <= CULL_REAR;
      cfg.winding_invert  <= 1'b0;
      cfg.two_sided_light <= 1'b0;
    end else if (wr) begin
      case (idx)
        REG_CULL_ENABLE:     cfg.cull_enable     <= pwdata[0];
        REG_CULL_FACE_MODE:  cfg.cull_face_mode  <= pwdata[1:0];
        REG_WINDING_INVERT:  cfg.winding_invert  <= pwdata[0];
        REG_TWO_SIDED_LIGHT: cfg.two_sided_light <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_CULL_ENABLE:     prdata[0]   = cfg.cull_enable;
      REG_CULL_FACE_MODE:  prdata[1:0] = cfg.cull_face_mode;
      REG_WINDING_INVERT:  prdata[0]   = cfg.winding_invert;
      REG_TWO_SIDED_LIGHT: prdata[0]   = cfg.two_sided_light;
      default:             prdata      = '0;
    endcase
  end

endmodule
`default_nettype wire

[rtl/cst_cofactor.sv]
// Two stages: x*y products, then 2x2 cofactors shifted down by the cofactor shift.
`default_nettype none
module cst_cofactor import cst_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire cst_tri_t        tri_d,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic signed [CE_W-1:0]    cof [3],
  output logic signed [COORD_W-1:0] w_out [3]
);

  // stage A: products
  logic                       va;
  logic signed [PROD_W-1:0]   pa [3];
  logic signed [PROD_W-1:0]   pb [3];
  logic signed [COORD_W-1:0]  wa [3];
  logic                       rdy_a;
  // stage B: shifted cofactors
  logic                       rdy_b;
  logic signed [COF_W-1:0]    diff [3];
  logic signed [COF_W-1:0]    shf  [3];

  assign rdy_b    = !out_valid || out_ready;
  assign rdy_a    = !va || rdy_b;
  assign in_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (rdy_a) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      pa[0] <= $signed(tri_d.v1_x) * $signed(tri_d.v2_y);
      pb[0] <= $signed(tri_d.v2_x) * $signed(tri_d.v1_y);
      pa[1] <= $signed(tri_d.v0_x) * $signed(tri_d.v2_y);
      pb[1] <= $signed(tri_d.v2_x) * $signed(tri_d.v0_y);
      pa[2] <= $signed(tri_d.v0_x) * $signed(tri_d.v1_y);
      pb[2] <= $signed(tri_d.v1_x) * $signed(tri_d.v0_y);
      wa[0] <= tri_d.v0_w;
      wa[1] <= tri_d.v1_w;
      wa[2] <= tri_d.v2_w;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = COF_W'(pa[i]) - COF_W'(pb[i]);
      shf[i]  = diff[i] >>> COF_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_b) begin
      out_valid <= va;
    end
  end

  // the shifted value fits in CS_W <= CE_W bits, so the low bits carry it whole
  always_ff @(posedge clk) begin
    if (rdy_b && va) begin
      for (int i = 0; i < 3; i++) begin
        cof[i]   <= shf[i][CE_W-1:0];
        w_out[i] <= wa[i];
      end
    end
  end

endmodule
`default_nettype wire

[rtl/cst_wmul.sv]
// Two stages: cofactor times w as low/high partial products, then recombined terms.
`default_nettype none
module cst_wmul import cst_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [CE_W-1:0]    cof [3],
  input  wire logic signed [COORD_W-1:0] w_in [3],
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [TERM_W-1:0] term [3]
);

  logic                     vc;
  logic                     rdy_c;
  logic                     rdy_d;
  logic signed [PL_W-1:0]   pl [3];
  logic signed [PH_W-1:0]   ph [3];
  logic signed [TERM_W-1:0] pl_x [3];
  logic signed [TERM_W-1:0] ph_x [3];

  assign rdy_d    = !out_valid || out_ready;
  assign rdy_c    = !vc || rdy_d;
  assign in_ready = rdy_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (rdy_c) begin
      vc <= in_valid;
    end
  end

  // low word is unsigned, high part carries the sign
  always_ff @(posedge clk) begin
    if (rdy_c && in_valid) begin
      for (int i = 0; i < 3; i++) begin
        pl[i] <= $signed({1'b0, cof[i][COORD_W-1:0]}) * w_in[i];
        ph[i] <= $signed(cof[i][CE_W-1:COORD_W]) * w_in[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pl_x[i] = TERM_W'(pl[i]);
      ph_x[i] = $signed({ph[i], {COORD_W{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_d) begin
      out_valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_d && vc) begin
      for (int i = 0; i < 3; i++) begin
        term[i] <= ph_x[i] + pl_x[i];
      end
    end
  end

endmodule
`default_nettype wire

[rtl/cst_decide.sv]
// Two stages: determinant sum, then facing sign and cull decision into the result register.
`default_nettype none
module cst_decide import cst_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [TERM_W-1:0] term [3],
  input  wire cst_cfg_t                 cfg,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          accept,
  output logic                          back_colors,
  output logic signed [1:0]             face_sign
);

  logic                    ve;
  logic                    rdy_e;
  logic                    rdy_f;
  logic signed [SUM_W-1:0] sum;
  logic                    neg;
  logic                    pos;
  logic                    culled;
  logic                    acc_next;

  assign rdy_f    = !out_valid || out_ready;
  assign rdy_e    = !ve || rdy_f;
  assign in_ready = rdy_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (rdy_e) begin
      ve <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_e && in_valid) begin
      sum <= SUM_W'(term[0]) - SUM_W'(term[1]) + SUM_W'(term[2]);
    end
  end

  // sign of sum >>> FRAC_BITS
  assign neg = sum[SUM_W-1];
  assign pos = !neg && (|sum[SUM_W-2:FRAC_BITS]);

  always_comb begin
    case (cfg.cull_face_mode)
      CULL_BOTH: culled = 1'b1;
      CULL_REAR: culled = neg ^ cfg.winding_invert;
      default:   culled = pos ^ cfg.winding_invert;
    endcase
    acc_next = !(cfg.cull_enable && culled);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_f) begin
      out_valid <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_f && ve) begin
      accept      <= acc_next;
      back_colors <= acc_next && cfg.two_sided_light && culled;
      face_sign   <= neg ? FACE_NEG : (pos ? FACE_POS : FACE_ZERO);
    end
  end

endmodule
`default_nettype wire

[rtl/clip_space_triangle_cull_core.sv]
// Top level of the clip-space triangle cull core: pipeline, registers and checks.
//
//  channel   | kind        | beat contents
//  ----------+-------------+----------------------------------------------
//  triangle  | valid/ready | v0..v2 x, y, w (signed 32-bit fixed point)
//  result    | valid/ready | accept, back_colors, face_sign (-1/0/+1)
//  apb       | psel/penable| cull_enable @0x0, cull_face_mode @0x4,
//            |             | winding_invert @0x8, two_sided_light @0xC
//
// One triangle beat per cycle while no held result backs up the pipe; each beat
// spends six register stages (products, cofactors, partial products, terms,
// sum, decision). The first stage loads at the accepting edge, and the result
// beat is on the port once the decision stage has loaded.
// Each stage moves when it is empty or its successor moves, so bubbles
// collapse and a held result stalls only the stages that are full behind it.
// Synchronous reset empties the pipeline and loads register defaults.
`default_nettype none
module clip_space_triangle_cull_core import cst_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  cst_tri_if.sink                triangle,
  cst_res_if.source              result,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  cst_cfg_t                  cfg;
  cst_tri_t                  tri_d;

  // cofactor -> multiply
  logic                      cof_valid;
  logic                      cof_ready;
  logic signed [CE_W-1:0]    cof [3];
  logic signed [COORD_W-1:0] cof_w [3];

  // multiply -> decision
  logic                      term_valid;
  logic                      term_ready;
  logic signed [TERM_W-1:0]  term [3];

  assign tri_d.v0_x = triangle.v0_x;
  assign tri_d.v0_y = triangle.v0_y;
  assign tri_d.v0_w = triangle.v0_w;
  assign tri_d.v1_x = triangle.v1_x;
  assign tri_d.v1_y = triangle.v1_y;
  assign tri_d.v1_w = triangle.v1_w;
  assign tri_d.v2_x = triangle.v2_x;
  assign tri_d.v2_y = triangle.v2_y;
  assign tri_d.v2_w = triangle.v2_w;

  cst_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stages 1-2: 2x2 cofactors
  cst_cofactor u_cofactor (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (triangle.valid),
    .in_ready  (triangle.ready),
    .tri_d     (tri_d),
    .out_valid (cof_valid),
    .out_ready (cof_ready),
    .cof       (cof),
    .w_out     (cof_w)
  );

  // stages 3-4: cofactor * w, split into a 33x32 low and a 13x32 high product per term
  cst_wmul u_wmul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cof_valid),
    .in_ready  (cof_ready),
    .cof       (cof),
    .w_in      (cof_w),
    .out_valid (term_valid),
    .out_ready (term_ready),
    .term      (term)
  );

  // stages 5-6: determinant sum, then facing and cull verdict
  cst_decide u_decide (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (term_valid),
    .in_ready    (term_ready),
    .term        (term),
    .cfg         (cfg),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .accept      (result.accept),
    .back_colors (result.back_colors),
    .face_sign   (result.face_sign)
  );

  // A rejected triangle never selects the back color set.
  a_reject_front_colors: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.accept || !result.back_colors))
    else $error("rejected triangle with back colors");

  // The sign code is only ever -1, 0 or +1.
  a_face_sign_code: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.face_sign == FACE_NEG || result.face_sign == FACE_ZERO ||
                      result.face_sign == FACE_POS))
    else $error("bad face sign code");

  // Input backpressure can only come from a held result at the far end.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !triangle.ready |-> (result.valid && !result.ready))
    else $error("input stalled without output backpressure");

  // Nothing leaves the pipe in the first cycles after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire
